[hw/rtl/rmap_pkg.sv]
// Shared types and constants of the touch to joystick radial map.
// Depends on nothing; the core and the checker import it.
package rmap_pkg;

  localparam int TOUCH_W = 12;
  localparam int AXIS_W  = 16;
  localparam int RAD_W   = 15;               // width of the output radius
  localparam int T2_W    = 25;               // squared offset length
  localparam int SQ_IN_W = T2_W + 16;        // squared length in Q16
  localparam int LEN_W   = 21;               // length in Q8
  localparam int MAG_W   = TOUCH_W + RAD_W;  // offset magnitude times radius
  localparam int NUM_W   = MAG_W + 16;       // dividend
  localparam int Q_W     = 23;               // deflection magnitude in Q8

  // Cycles from the accepting edge until the result strobe is sampled.
  localparam int LATENCY = 4 + LEN_W + 1 + Q_W + 2;

  localparam logic [2:0] CFG_TOUCH_CX  = 3'd0;
  localparam logic [2:0] CFG_TOUCH_CY  = 3'd1;
  localparam logic [2:0] CFG_TOUCH_RAD = 3'd2;
  localparam logic [2:0] CFG_INNER_RAD = 3'd3;
  localparam logic [2:0] CFG_OUTER_RAD = 3'd4;
  localparam logic [2:0] CFG_OUT_CX    = 3'd5;
  localparam logic [2:0] CFG_OUT_CY    = 3'd6;
  localparam logic [2:0] CFG_INVERT    = 3'd7;

  localparam logic [1:0] ZONE_OUTSIDE = 2'd0;
  localparam logic [1:0] ZONE_INNER   = 2'd1;
  localparam logic [1:0] ZONE_ACTIVE  = 2'd2;

  typedef struct packed {
    logic [TOUCH_W-1:0] touch_x;
    logic [TOUCH_W-1:0] touch_y;
  } in_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic [1:0]               zone;
  } out_t;

  // Side data that rides along the square root pipeline.
  typedef struct packed {
    logic [1:0]       zone;
    logic             linear;
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
  } sq_sb_t;

  // Side data that rides along the divider pipeline.
  typedef struct packed {
    logic [1:0] zone;
    logic       kill;
    logic       neg_x;
    logic       neg_y;
  } div_sb_t;

endpackage

[hw/rtl/rmap_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per register stage.
// Stand-alone; carries an opaque side vector alongside each beat.
module rmap_sqrt_pipe #(
  parameter int V_W  = 41,
  parameter int R_W  = 21,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [V_W-1:0]  in_val,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_vld,
  output logic [R_W-1:0]  out_root,
  output logic [SB_W-1:0] out_sb
);

  localparam int W = V_W + 2;

  logic            vld_r  [0:R_W-1];
  logic [W-1:0]    rem_r  [0:R_W-1];
  logic [R_W-1:0]  root_r [0:R_W-1];
  logic [SB_W-1:0] sb_r   [0:R_W-1];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    localparam int B = R_W - 1 - k;
    logic            vld_in;
    logic [W-1:0]    rem_in;
    logic [R_W-1:0]  root_in;
    logic [SB_W-1:0] sb_in;
    logic [W-1:0]    trial;
    logic [W-1:0]    rem_nxt;
    logic [R_W-1:0]  root_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = W'(in_val);
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    always_comb begin
      trial    = (W'(root_in) << (B + 1)) + (W'(1) << (2 * B));
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = root_in | (R_W'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      sb_r[k]   <= sb_in;
    end
  end

  assign out_vld  = vld_r[R_W-1];
  assign out_root = root_r[R_W-1];
  assign out_sb   = sb_r[R_W-1];

endmodule

[hw/rtl/rmap_div_pipe.sv]
// Pipelined restoring divider of two dividends by one shared divisor.
// One quotient bit per stage; the quotient must stay below 2**Q_W.
module rmap_div_pipe #(
  parameter int NUM_W = 43,
  parameter int DEN_W = 21,
  parameter int Q_W   = 23,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num_a,
  input  logic [NUM_W-1:0] in_num_b,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_vld,
  output logic [Q_W-1:0]   out_q_a,
  output logic [Q_W-1:0]   out_q_b,
  output logic [SB_W-1:0]  out_sb
);

  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             vld_r [0:Q_W-1];
  logic [W-1:0]     ra_r  [0:Q_W-1];
  logic [W-1:0]     rb_r  [0:Q_W-1];
  logic [Q_W-1:0]   qa_r  [0:Q_W-1];
  logic [Q_W-1:0]   qb_r  [0:Q_W-1];
  logic [DEN_W-1:0] den_r [0:Q_W-1];
  logic [SB_W-1:0]  sb_r  [0:Q_W-1];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic             vld_in;
    logic [W-1:0]     ra_in, rb_in;
    logic [Q_W-1:0]   qa_in, qb_in;
    logic [DEN_W-1:0] den_in;
    logic [SB_W-1:0]  sb_in;
    logic [W-1:0]     dsh;
    logic [W-1:0]     ra_nxt, rb_nxt;
    logic [Q_W-1:0]   qa_nxt, qb_nxt;

    if (k == 0) begin : g_first
      assign vld_in = in_vld;
      assign ra_in  = W'(in_num_a);
      assign rb_in  = W'(in_num_b);
      assign qa_in  = '0;
      assign qb_in  = '0;
      assign den_in = in_den;
      assign sb_in  = in_sb;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign ra_in  = ra_r[k-1];
      assign rb_in  = rb_r[k-1];
      assign qa_in  = qa_r[k-1];
      assign qb_in  = qb_r[k-1];
      assign den_in = den_r[k-1];
      assign sb_in  = sb_r[k-1];
    end

    always_comb begin
      dsh    = W'(den_in) << B;
      ra_nxt = ra_in;
      rb_nxt = rb_in;
      qa_nxt = qa_in;
      qb_nxt = qb_in;
      if (ra_in >= dsh) begin
        ra_nxt = ra_in - dsh;
        qa_nxt = qa_in | (Q_W'(1) << B);
      end
      if (rb_in >= dsh) begin
        rb_nxt = rb_in - dsh;
        qb_nxt = qb_in | (Q_W'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      ra_r[k]  <= ra_nxt;
      rb_r[k]  <= rb_nxt;
      qa_r[k]  <= qa_nxt;
      qb_r[k]  <= qb_nxt;
      den_r[k] <= den_in;
      sb_r[k]  <= sb_in;
    end
  end

  assign out_vld = vld_r[Q_W-1];
  assign out_q_a = qa_r[Q_W-1];
  assign out_q_b = qb_r[Q_W-1];
  assign out_sb  = sb_r[Q_W-1];

endmodule

[hw/rtl/touch_to_joystick_radial_map_core.sv]
// Pipeline: 4 front stages, 21 square root stages, 1 set-up stage, 23 divider stages
// and 2 output stages.
// Throughput: one beat per cycle; busy never rises and the receiver cannot stall.
// Reset: synchronous, active low; it empties the pipeline and loads the register defaults.
// Depends on rmap_pkg, rmap_sqrt_pipe and rmap_div_pipe.
module touch_to_joystick_radial_map_core #(
  parameter int unsigned OUT_RADIUS = 32767
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rmap_pkg::in_t in_data,
  output logic          out_valid,
  output rmap_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_wdata
);

  import rmap_pkg::*;

  // The pipeline never holds a beat back, so a start is always taken.
  assign busy = 1'b0;

  logic in_fire;
  assign in_fire = start && !busy;

  // Configuration registers. The user must write them only while the pipeline is empty,
  // as every stage reads them directly; the block itself does not enforce this.
  logic [TOUCH_W-1:0]       cx_r, cy_r, rad_r, inr_r, outr_r;
  logic signed [AXIS_W-1:0] ocx_r, ocy_r;
  logic [1:0]               inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= 12'd2048;
      cy_r   <= 12'd2048;
      rad_r  <= 12'd1024;
      inr_r  <= 12'd0;
      outr_r <= 12'd1024;
      ocx_r  <= 16'sd0;
      ocy_r  <= 16'sd0;
      inv_r  <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOUCH_CX:  cx_r   <= cfg_wdata[TOUCH_W-1:0];
        CFG_TOUCH_CY:  cy_r   <= cfg_wdata[TOUCH_W-1:0];
        CFG_TOUCH_RAD: rad_r  <= cfg_wdata[TOUCH_W-1:0];
        CFG_INNER_RAD: inr_r  <= cfg_wdata[TOUCH_W-1:0];
        CFG_OUTER_RAD: outr_r <= cfg_wdata[TOUCH_W-1:0];
        CFG_OUT_CX:    ocx_r  <= $signed(cfg_wdata);
        CFG_OUT_CY:    ocy_r  <= $signed(cfg_wdata);
        CFG_INVERT:    inv_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Squared radii for the zone tests, refreshed every cycle from the registers.
  logic [2*TOUCH_W-1:0] r2_r, i2_r, o2_r;

  always_ff @(posedge clk) begin
    r2_r <= {{TOUCH_W{1'b0}}, rad_r} * {{TOUCH_W{1'b0}}, rad_r};
    i2_r <= {{TOUCH_W{1'b0}}, inr_r} * {{TOUCH_W{1'b0}}, inr_r};
    o2_r <= {{TOUCH_W{1'b0}}, outr_r} * {{TOUCH_W{1'b0}}, outr_r};
  end

  logic [RAD_W-1:0] radius;
  assign radius = RAD_W'(OUT_RADIUS);

  // Stage 1: offset from the touch centre.
  logic                      s1_vld_r;
  logic signed [TOUCH_W:0]   s1_dx_r, s1_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx_r <= $signed({1'b0, in_data.touch_x}) - $signed({1'b0, cx_r});
    s1_dy_r <= $signed({1'b0, in_data.touch_y}) - $signed({1'b0, cy_r});
  end

  // Stage 2: magnitudes, their squares and their products with the output radius.
  logic [TOUCH_W:0]     abs_x_full, abs_y_full;
  logic [TOUCH_W-1:0]   abs_x, abs_y;
  logic                 s2_vld_r;
  logic [2*TOUCH_W-1:0] s2_sqx_r, s2_sqy_r;
  logic [MAG_W-1:0]     s2_mx_r, s2_my_r;
  logic                 s2_sx_r, s2_sy_r;

  assign abs_x_full = s1_dx_r[TOUCH_W] ? 13'(-s1_dx_r) : 13'(s1_dx_r);
  assign abs_y_full = s1_dy_r[TOUCH_W] ? 13'(-s1_dy_r) : 13'(s1_dy_r);
  // An offset never reaches 4096 in size, so twelve bits hold the magnitude.
  assign abs_x = abs_x_full[TOUCH_W-1:0];
  assign abs_y = abs_y_full[TOUCH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sqx_r <= {{TOUCH_W{1'b0}}, abs_x} * {{TOUCH_W{1'b0}}, abs_x};
    s2_sqy_r <= {{TOUCH_W{1'b0}}, abs_y} * {{TOUCH_W{1'b0}}, abs_y};
    s2_mx_r  <= MAG_W'(abs_x) * MAG_W'(radius);
    s2_my_r  <= MAG_W'(abs_y) * MAG_W'(radius);
    s2_sx_r  <= s1_dx_r[TOUCH_W];
    s2_sy_r  <= s1_dy_r[TOUCH_W];
  end

  // Stage 3: squared length.
  logic              s3_vld_r;
  logic [T2_W-1:0]   s3_t2_r;
  logic [MAG_W-1:0]  s3_mx_r, s3_my_r;
  logic              s3_sx_r, s3_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_t2_r <= T2_W'(s2_sqx_r) + T2_W'(s2_sqy_r);
    s3_mx_r <= s2_mx_r;
    s3_my_r <= s2_my_r;
    s3_sx_r <= s2_sx_r;
    s3_sy_r <= s2_sy_r;
  end

  // Stage 4: zone decision. The outside test comes first and the inner
  // dead zone test second, so outside wins over an inner radius past the touch radius.
  logic            s4_vld_r;
  logic [T2_W-1:0] s4_t2_r;
  sq_sb_t          s4_sb_r;
  logic [1:0]      zone_nxt;

  always_comb begin
    if (s3_t2_r > T2_W'(r2_r)) begin
      zone_nxt = ZONE_OUTSIDE;
    end else if (s3_t2_r < T2_W'(i2_r)) begin
      zone_nxt = ZONE_INNER;
    end else begin
      zone_nxt = ZONE_ACTIVE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_t2_r        <= s3_t2_r;
    s4_sb_r.zone   <= zone_nxt;
    s4_sb_r.linear <= (s3_t2_r <= T2_W'(o2_r));
    s4_sb_r.neg_x  <= s3_sx_r;
    s4_sb_r.neg_y  <= s3_sy_r;
    s4_sb_r.mag_x  <= s3_mx_r;
    s4_sb_r.mag_y  <= s3_my_r;
  end

  // Length in Q8 as the root of the squared length in Q16. It is only
  // used in the clamped region but is formed for every beat.
  logic             sq_vld;
  logic [LEN_W-1:0] sq_len;
  sq_sb_t           sq_sb;

  rmap_sqrt_pipe #(
    .V_W  (SQ_IN_W),
    .R_W  (LEN_W),
    .SB_W ($bits(sq_sb_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_val   ({s4_t2_r, 16'd0}),
    .in_sb    (s4_sb_r),
    .out_vld  (sq_vld),
    .out_root (sq_len),
    .out_sb   (sq_sb)
  );

  // Set-up stage: pick the divisor. In the linear region the outer radius is
  // scaled by 256 so that one Q16 dividend serves both regions. A zero
  // divisor, or any zone other than the active one, kills the deflection.
  logic             su_vld_r;
  logic [NUM_W-1:0] su_nx_r, su_ny_r;
  logic [LEN_W-1:0] su_den_r;
  div_sb_t          su_sb_r;
  logic [LEN_W-1:0] den_nxt;

  assign den_nxt = sq_sb.linear ? LEN_W'({outr_r, 8'd0}) : sq_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_vld_r <= 1'b0;
    end else begin
      su_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    su_nx_r       <= {sq_sb.mag_x, 16'd0};
    su_ny_r       <= {sq_sb.mag_y, 16'd0};
    su_den_r      <= den_nxt;
    su_sb_r.zone  <= sq_sb.zone;
    su_sb_r.kill  <= (sq_sb.zone != ZONE_ACTIVE) || (den_nxt == '0);
    su_sb_r.neg_x <= sq_sb.neg_x;
    su_sb_r.neg_y <= sq_sb.neg_y;
  end

  // Deflection magnitudes in Q8. They never exceed the output radius times
  // 256, which keeps the quotient inside the divider's bit count.
  logic           dv_vld;
  logic [Q_W-1:0] dv_qx, dv_qy;
  div_sb_t        dv_sb;

  rmap_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (LEN_W),
    .Q_W   (Q_W),
    .SB_W  ($bits(div_sb_t))
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (su_vld_r),
    .in_num_a (su_nx_r),
    .in_num_b (su_ny_r),
    .in_den   (su_den_r),
    .in_sb    (su_sb_r),
    .out_vld  (dv_vld),
    .out_q_a  (dv_qx),
    .out_q_b  (dv_qy),
    .out_sb   (dv_sb)
  );

  function automatic logic signed [AXIS_W-1:0] sat16(input logic signed [17:0] v);
    logic signed [AXIS_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[AXIS_W-1:0];
    end
    return r;
  endfunction

  // Centre in Q8 plus the signed deflection, truncated toward zero.
  function automatic logic signed [AXIS_W-1:0] finish_axis(
    input logic signed [AXIS_W-1:0] centre,
    input logic [Q_W-1:0]           mag,
    input logic                     neg,
    input logic                     kill
  );
    logic signed [Q_W:0]  d;
    logic signed [25:0]   s;
    logic signed [25:0]   t;
    d = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (kill) begin
      d = '0;
    end
    s = 26'($signed({centre, 8'd0})) + 26'(d);
    t = s[25] ? ((s + 26'sd255) >>> 8) : (s >>> 8);
    return sat16(t[17:0]);
  endfunction

  // Output stage 1: axis values before inversion.
  logic                     f1_vld_r;
  logic signed [AXIS_W-1:0] f1_ax_r, f1_ay_r;
  logic [1:0]               f1_zone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    f1_ax_r   <= finish_axis(ocx_r, dv_qx, dv_sb.neg_x, dv_sb.kill);
    f1_ay_r   <= finish_axis(ocy_r, dv_qy, dv_sb.neg_y, dv_sb.kill);
    f1_zone_r <= dv_sb.zone;
  end

  // Output stage 2: optional mirror to centre plus radius minus axis. It applies in every
  // zone, so a centred stick is mirrored too.
  logic signed [17:0]       mir_x, mir_y;
  logic                     out_vld_r;
  out_t                     out_r;

  assign mir_x = 18'(ocx_r) + $signed({3'd0, radius}) - 18'(f1_ax_r);
  assign mir_y = 18'(ocy_r) + $signed({3'd0, radius}) - 18'(f1_ay_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r.axis_x <= inv_r[0] ? sat16(mir_x) : f1_ax_r;
    out_r.axis_y <= inv_r[1] ? sat16(mir_y) : f1_ay_r;
    out_r.zone   <= f1_zone_r;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/rmap_checker.sv]
// Port-level checks of the radial map core and the bind that attaches them.
// Depends on rmap_pkg for the pipeline latency and the result type.
module rmap_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input rmap_pkg::out_t out_data
);

  import rmap_pkg::*;

  // Every accepted beat yields a result strobe after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted beat produced no result strobe");

  // No strobe appears without a beat accepted the latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without an accepted beat");

  // Back-to-back beats come out as back-to-back results.
  a_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) ##1 (start && !busy) |-> ##(LATENCY - 1) (out_valid ##1 out_valid))
    else $error("consecutive beats did not give consecutive results");

  // The zone code of a result is never the unused code.
  a_zone_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.zone != 2'b11))
    else $error("result carries an unused zone code");

endmodule

bind touch_to_joystick_radial_map_core rmap_checker u_rmap_checker (.*);
